// ===== src/ahum_pkg.sv =====
// ----------------------------------------------------------------------------
// Absolute humidity package
// Field widths, fixed-point constants, sideband types and the function that
// builds the 2^f interpolation table at elaboration.
// ----------------------------------------------------------------------------
package ahum_pkg;

   localparam int TEMP_W   = 15;
   localparam int RH_W     = 14;
   localparam int MG_W     = 18;

   localparam int MAG_W    = 56;
   localparam int DEN1_W   = 22;
   localparam int NUM1_W   = 57;
   localparam int Q1_W     = 37;
   localparam int FRAC_W   = 30;
   localparam int K_W      = Q1_W - FRAC_W + 2;
   localparam int D_W      = 23;
   localparam int DLIM_W   = 41;
   localparam int HS_W     = 35;
   localparam int ENTRY_W  = 32;
   localparam int PROD_W   = ENTRY_W + FRAC_W;
   localparam int M24_W    = 26;
   localparam int A_W      = 61;
   localparam int DD_W     = 64;
   localparam int LIM_W    = 81;
   localparam int SH_W     = 6;
   localparam int Q2_W     = MG_W;

   localparam int AHUM_EXP_ENTRIES = 64;
   localparam int TAYLOR_TERMS     = 24;

   localparam logic [63:0] LOG2E_Q30   = 64'd1549082005;
   localparam logic [63:0] MAGNUS_COEF = 64'd1762;
   localparam logic [63:0] LOG2E_COEF  = MAGNUS_COEF * LOG2E_Q30;
   localparam logic [63:0] SCALE_NUM   = 64'd1320192;
   localparam logic [63:0] LN2_Q60     = 64'h0B17_217F_7D1C_F79B;
   localparam logic [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
   localparam int          MAGNUS_OFFS = 24312;
   localparam int          KELVIN_OFFS = 27315;
   localparam int          LIMIT_MG    = 256000;
   localparam int          EXP_BIAS    = 24;
   localparam int          SH_MAX      = 40;

   typedef struct packed {
      logic              neg;
      logic [D_W-1:0]    d;
      logic [DLIM_W-1:0] dlim;
      logic [HS_W-1:0]   hs;
   } ahum_div1_side_type;

   typedef struct packed {
      logic signed [K_W-1:0] k;
      logic [D_W-1:0]        d;
      logic [DLIM_W-1:0]     dlim;
      logic [HS_W-1:0]       hs;
   } ahum_pow_side_type;

   typedef struct packed {
      logic over;
      logic tiny;
   } ahum_div2_side_type;

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic logic [ENTRY_W-1:0] pow2_entry(input logic [63:0] z);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] rnd;
      term = Q60_ONE;
      sum  = Q60_ONE;
      for (int j = 1; j <= TAYLOR_TERMS; j++) begin
         term = mul_q60(term, z) / 64'(j);
         sum  = sum + term;
      end
      rnd = (sum + 64'h2000_0000) >> 30;
      return rnd[ENTRY_W-1:0];
   endfunction

endpackage

// ===== src/ahum_if.sv =====
// ----------------------------------------------------------------------------
// Absolute humidity channels
// Valid/ready channels for the sample words and the result words.
// ----------------------------------------------------------------------------
interface ahum_req_if;
   import ahum_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi;
   logic [RH_W-1:0]          rel_humidity_centi;

   modport source (output valid, temperature_centi, rel_humidity_centi, input ready);
   modport sink (input valid, temperature_centi, rel_humidity_centi, output ready);
endinterface

interface ahum_rsp_if;
   import ahum_pkg::*;

   logic            valid;
   logic            ready;
   logic [MG_W-1:0] abs_humidity_mg;
   logic            out_of_range;

   modport source (output valid, abs_humidity_mg, out_of_range, input ready);
   modport sink (input valid, abs_humidity_mg, out_of_range, output ready);
endinterface

// ===== src/ahum_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, most significant first. The numerator shifted
// right by the quotient width must be below the divisor.
// ----------------------------------------------------------------------------
module ahum_div #(
   parameter int NUM_W  = 57,
   parameter int DEN_W  = 22,
   parameter int QUO_W  = 37,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);
   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  low_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic              valid_src;
      logic [DEN_W-1:0]  rem_src;
      logic [QUO_W-1:0]  low_src;
      logic [QUO_W-1:0]  quo_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W:0]    trial;
      logic              fit;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = DEN_W'(num >> QUO_W);
         assign low_src   = num[QUO_W-1:0];
         assign quo_src   = '0;
         assign den_src   = den;
         assign side_src  = side_in;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign low_src   = low_ff[s-1];
         assign quo_src   = quo_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      assign trial = {rem_src, low_src[QUO_W-1]};
      assign fit   = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= fit ? DEN_W'(trial - {1'b0, den_src}) : DEN_W'(trial);
            low_ff[s]  <= low_src << 1;
            quo_ff[s]  <= {quo_src[QUO_W-2:0], fit};
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];
endmodule

// ===== src/ahum_pow2.sv =====
// ----------------------------------------------------------------------------
// Interpolated power of two
// Four stages: table position, registered table read, slope product, and the
// interpolated value rounded to Q24.
// ----------------------------------------------------------------------------
module ahum_pow2 #(
   parameter int ENTRIES = 64,
   parameter int SIDE_W  = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [ahum_pkg::FRAC_W-1:0] frac,
   input  logic [SIDE_W-1:0]           side_in,
   output logic                        out_valid,
   output logic [ahum_pkg::M24_W-1:0]  m24,
   output logic [SIDE_W-1:0]           side_out
);
   import ahum_pkg::*;

   localparam int          IDX_W  = $clog2(ENTRIES + 1);
   localparam int          POS_W  = FRAC_W + IDX_W;
   localparam logic [63:0] Z_STEP = LN2_Q60 / 64'(ENTRIES);
   localparam logic [63:0] Z_REM  = LN2_Q60 % 64'(ENTRIES);

   logic [ENTRY_W-1:0] tab [ENTRIES+1];

   for (genvar g = 0; g <= ENTRIES; g++) begin : g_tab
      localparam logic [63:0] Z = Z_STEP * 64'(g)
                                  + (Z_REM * 64'(g) + 64'(ENTRIES / 2)) / 64'(ENTRIES);
      assign tab[g] = pow2_entry(Z);
   end

   logic [POS_W-1:0]   pos;
   logic [IDX_W-1:0]   idx_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [FRAC_W-1:0]  w1_ff;
   logic [FRAC_W-1:0]  w2_ff;
   logic [ENTRY_W-1:0] e0_ff;
   logic [ENTRY_W-1:0] e1_ff;
   logic [ENTRY_W-1:0] e0_3_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ENTRY_W:0]   m_in;
   logic [M24_W-1:0]   m24_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SIDE_W-1:0]  s1_ff, s2_ff, s3_ff, s4_ff;

   always_comb begin
      pos = POS_W'(frac) * POS_W'(ENTRIES);
      if (pos[POS_W-1:FRAC_W] >= IDX_W'(ENTRIES)) begin
         idx_in = IDX_W'(ENTRIES - 1);
      end else begin
         idx_in = pos[POS_W-1:FRAC_W];
      end
      m_in = {1'b0, e0_3_ff} + (ENTRY_W+1)'((prod_ff + PROD_W'(64'h2000_0000)) >> FRAC_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff  <= idx_in;
         w1_ff   <= pos[FRAC_W-1:0];
         s1_ff   <= side_in;
         e0_ff   <= tab[idx_ff];
         e1_ff   <= tab[IDX_W'(idx_ff + 1'b1)];
         w2_ff   <= w1_ff;
         s2_ff   <= s1_ff;
         prod_ff <= PROD_W'(e1_ff - e0_ff) * PROD_W'(w2_ff);
         e0_3_ff <= e0_ff;
         s3_ff   <= s2_ff;
         m24_ff  <= M24_W'((m_in + (ENTRY_W+1)'(32)) >> 6);
         s4_ff   <= s3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign m24       = m24_ff;
   assign side_out  = s4_ff;
endmodule

// ===== src/absolute_humidity_from_temp_rh.sv =====
// ----------------------------------------------------------------------------
// Absolute humidity from temperature and relative humidity
// Magnus formula in fixed point: exponent division, interpolated 2^f, scale
// multiply and rounding division, with a range check on the result.
// ----------------------------------------------------------------------------
// Usage:
// A sample word enters on req_bus (temperature in 0.01 degC, humidity in
// 0.01 %RH) when valid and ready are both high. One result word leaves on
// rsp_bus: the absolute humidity in mg/m^3, or zero with out_of_range set
// when the value reaches 256000.
// The datapath is a pipeline that takes one word per clock while req_bus.ready
// is high; the two pipelined dividers (37 and 18 stages) make up most of its
// depth.
// An output register plus a skid register sit behind the pipeline. While the
// receiver stalls, the pipeline keeps taking samples until the skid register
// fills; then req_bus.ready drops and every stage holds its word.
// Reset clears all valid bits, output and skid register included; the table
// is built at elaboration, so the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module absolute_humidity_from_temp_rh #(
   parameter int EXP_TABLE_ENTRIES = ahum_pkg::AHUM_EXP_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   ahum_req_if.sink   req_bus,
   ahum_rsp_if.source rsp_bus
);
   import ahum_pkg::*;

   logic adv;

   // Input register.
   logic                     v0_ff;
   logic signed [TEMP_W-1:0] t0_ff;
   logic [RH_W-1:0]          h0_ff;

   // Products and denominators.
   logic [TEMP_W-1:0]  tabs;
   logic               v1_ff;
   logic               neg1_ff;
   logic [MAG_W-1:0]   mag1_ff;
   logic [DEN1_W-1:0]  den1_ff;
   logic [D_W-1:0]     d1_ff;
   logic [DLIM_W-1:0]  dlim1_ff;
   logic [HS_W-1:0]    hs1_ff;

   // Rounded exponent numerator.
   logic               v2_ff;
   logic [NUM1_W-1:0]  num1_ff;
   logic [DEN1_W-1:0]  den2_ff;
   ahum_div1_side_type side2_ff;

   logic               div1_valid;
   logic [Q1_W-1:0]    div1_quo;
   ahum_div1_side_type div1_side;

   // Exponent split.
   logic               v3_ff;
   logic [FRAC_W-1:0]  frac3_ff;
   ahum_pow_side_type  side3_ff;
   logic [Q1_W-FRAC_W-1:0] qhi;
   logic [FRAC_W-1:0]  qlo;

   logic               pow_valid;
   logic [M24_W-1:0]   pow_m24;
   ahum_pow_side_type  pow_side;

   // Scale product and shift range.
   logic               v5_ff;
   logic [A_W-1:0]     a5_ff;
   logic               shneg5_ff;
   logic               shbig5_ff;
   logic [SH_W-1:0]    shamt5_ff;
   logic [D_W-1:0]     d5_ff;
   logic [DLIM_W-1:0]  dlim5_ff;

   // Shifted divisor, rounded numerator and limit.
   logic               v6_ff;
   logic [DD_W-1:0]    dd_in;
   logic [DD_W-1:0]    dd6_ff;
   logic [DD_W-1:0]    n6_ff;
   logic [LIM_W-1:0]   lim6_ff;
   logic               shneg6_ff;
   logic               shbig6_ff;

   // Range decision.
   logic               v7_ff;
   logic [DD_W-1:0]    dd7_ff;
   logic [DD_W-1:0]    n7_ff;
   ahum_div2_side_type side7_ff;

   logic               div2_valid;
   logic [Q2_W-1:0]    div2_quo;
   ahum_div2_side_type div2_side;

   // Output and skid registers.
   logic [MG_W-1:0]    res_mg;
   logic               take;
   logic               out_valid_ff;
   logic [MG_W-1:0]    out_mg_ff;
   logic               out_oor_ff;
   logic               skid_valid_ff;
   logic [MG_W-1:0]    skid_mg_ff;
   logic               skid_oor_ff;

   assign adv           = ~skid_valid_ff;
   assign req_bus.ready = adv;

   always_comb begin
      tabs  = t0_ff[TEMP_W-1] ? TEMP_W'(-t0_ff) : TEMP_W'(t0_ff);
      qhi   = div1_quo[Q1_W-1:FRAC_W];
      qlo   = div1_quo[FRAC_W-1:0];
      dd_in = DD_W'(d5_ff) << shamt5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_bus.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= div1_valid;
         v5_ff <= pow_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff    <= req_bus.temperature_centi;
         h0_ff    <= req_bus.rel_humidity_centi;

         neg1_ff  <= t0_ff[TEMP_W-1];
         mag1_ff  <= MAG_W'(64'(tabs) * LOG2E_COEF);
         den1_ff  <= DEN1_W'(100 * (MAGNUS_OFFS + int'(t0_ff)));
         d1_ff    <= D_W'(100 * (KELVIN_OFFS + int'(t0_ff)));
         dlim1_ff <= DLIM_W'(longint'(100 * LIMIT_MG) * longint'(KELVIN_OFFS + int'(t0_ff)));
         hs1_ff   <= HS_W'(64'(h0_ff) * SCALE_NUM);

         num1_ff       <= NUM1_W'(mag1_ff) + NUM1_W'(den1_ff >> 1);
         den2_ff       <= den1_ff;
         side2_ff.neg  <= neg1_ff;
         side2_ff.d    <= d1_ff;
         side2_ff.dlim <= dlim1_ff;
         side2_ff.hs   <= hs1_ff;

         if (div1_side.neg) begin
            side3_ff.k <= -(K_W'(qhi) + K_W'(qlo != '0));
            frac3_ff   <= FRAC_W'(-qlo);
         end else begin
            side3_ff.k <= K_W'(qhi);
            frac3_ff   <= qlo;
         end
         side3_ff.d    <= div1_side.d;
         side3_ff.dlim <= div1_side.dlim;
         side3_ff.hs   <= div1_side.hs;

         a5_ff     <= A_W'(64'(pow_side.hs) * 64'(pow_m24));
         shneg5_ff <= int'(pow_side.k) > EXP_BIAS;
         shbig5_ff <= int'(pow_side.k) < EXP_BIAS - SH_MAX;
         shamt5_ff <= SH_W'(EXP_BIAS - int'(pow_side.k));
         d5_ff     <= pow_side.d;
         dlim5_ff  <= pow_side.dlim;

         dd6_ff    <= dd_in;
         n6_ff     <= DD_W'(a5_ff) + (dd_in >> 1);
         lim6_ff   <= LIM_W'(dlim5_ff) << shamt5_ff;
         shneg6_ff <= shneg5_ff;
         shbig6_ff <= shbig5_ff;

         dd7_ff        <= dd6_ff;
         n7_ff         <= n6_ff;
         side7_ff.over <= shneg6_ff | (~shbig6_ff & (LIM_W'(n6_ff) >= lim6_ff));
         side7_ff.tiny <= shbig6_ff;
      end
   end

   ahum_div #(
      .NUM_W  (NUM1_W),
      .DEN_W  (DEN1_W),
      .QUO_W  (Q1_W),
      .SIDE_W ($bits(ahum_div1_side_type))
   ) u_exp_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .num       (num1_ff),
      .den       (den2_ff),
      .side_in   (side2_ff),
      .out_valid (div1_valid),
      .quo       (div1_quo),
      .side_out  (div1_side)
   );

   ahum_pow2 #(
      .ENTRIES (EXP_TABLE_ENTRIES),
      .SIDE_W  ($bits(ahum_pow_side_type))
   ) u_pow2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .frac      (frac3_ff),
      .side_in   (side3_ff),
      .out_valid (pow_valid),
      .m24       (pow_m24),
      .side_out  (pow_side)
   );

   ahum_div #(
      .NUM_W  (DD_W),
      .DEN_W  (DD_W),
      .QUO_W  (Q2_W),
      .SIDE_W ($bits(ahum_div2_side_type))
   ) u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v7_ff),
      .num       (n7_ff),
      .den       (dd7_ff),
      .side_in   (side7_ff),
      .out_valid (div2_valid),
      .quo       (div2_quo),
      .side_out  (div2_side)
   );

   assign res_mg = (div2_side.over | div2_side.tiny) ? '0 : div2_quo;
   assign take   = out_valid_ff & rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (div2_valid) begin
         if (out_valid_ff & ~take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_mg_ff  <= skid_mg_ff;
            out_oor_ff <= skid_oor_ff;
         end
      end else if (div2_valid) begin
         if (out_valid_ff & ~take) begin
            skid_mg_ff  <= res_mg;
            skid_oor_ff <= div2_side.over;
         end else begin
            out_mg_ff  <= res_mg;
            out_oor_ff <= div2_side.over;
         end
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.abs_humidity_mg = out_mg_ff;
   assign rsp_bus.out_of_range    = out_oor_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> skid_valid_ff && $stable(skid_mg_ff))
      else $error("skid word lost while the receiver stalls");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_oor_ff) |-> out_mg_ff == '0)
      else $error("flagged result carries a nonzero value");

   assert property (@(posedge clock)
      reset |=> !out_valid_ff && !skid_valid_ff)
      else $error("result word present right after reset");
endmodule
